@@ src/rmsu_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsu_pkg
// Types, constants and control store for the reward-modulated synapse
// update unit.
// ----------------------------------------------------------------------------
package rmsu_pkg;

    localparam logic [22:0]        ACTION_POTENTIAL = 23'd65536;
    localparam logic [16:0]        ONE_Q16          = 17'd65536;
    localparam logic signed [24:0] DEAD_BAND        = 25'sd65;
    localparam logic [16:0]        ELIG_THRESHOLD   = 17'd3276;
    localparam logic [16:0]        PATH_THRESHOLD   = 17'd655;
    localparam logic signed [33:0] S24_MAX          = 34'sd8388607;
    localparam logic signed [33:0] S24_MIN          = -34'sd8388608;

    localparam int unsigned CFG_W = 24;
    localparam int unsigned PC_W  = 4;

    typedef enum logic [2:0] {
        KIND_STIMULATE   = 3'd0,
        KIND_TICK        = 3'd1,
        KIND_REWARD      = 3'd2,
        KIND_DOPAMINE    = 3'd3,
        KIND_SCALE_ELIG  = 3'd4,
        KIND_WRITE_STR   = 3'd5,
        KIND_CLEAR       = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        REG_ELIG_DECAY = 3'd0,
        REG_ACT_DECAY  = 3'd1,
        REG_REST       = 3'd2,
        REG_LEAK       = 3'd3,
        REG_HEBB       = 3'd4,
        REG_PING       = 3'd5,
        REG_MAX        = 3'd6,
        REG_GAIN       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [16:0]        elig_decay;
        logic [16:0]        activation_decay;
        logic signed [23:0] rest_level;
        logic [15:0]        leak_step;
        logic [15:0]        hebb_step;
        logic [15:0]        pre_step;
        logic [22:0]        strength_cap;
        logic [19:0]        da_gain;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               pre_fired;
        logic               post_fired;
        logic signed [23:0] amount;
        logic [16:0]        factor;
    } in_t;

    typedef struct packed {
        logic signed [23:0] signal;
        logic               signal_valid;
        logic signed [23:0] strength_out;
        logic [16:0]        eligibility_out;
        logic [16:0]        activation_out;
        logic               path_active;
    } out_t;

    typedef enum logic [2:0] {
        MA_WEIGHT = 3'd0,
        MA_ELIG   = 3'd1,
        MA_ACT    = 3'd2,
        MA_AMOUNT = 3'd3,
        MA_PROD   = 3'd4
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_AP     = 3'd0,
        MB_EDECAY = 3'd1,
        MB_ADECAY = 3'd2,
        MB_ELIG   = 3'd3,
        MB_ACT    = 3'd4,
        MB_GAIN   = 3'd5,
        MB_FACTOR = 3'd6
    } mul_b_t;

    typedef enum logic [1:0] {
        TR_KEEP = 2'd0,
        TR_ONE  = 2'd1,
        TR_ZERO = 2'd2,
        TR_PROD = 2'd3
    } tr_op_t;

    typedef enum logic [2:0] {
        W_KEEP  = 3'd0,
        W_LOAD  = 3'd1,
        W_LEAK  = 3'd2,
        W_BOOST = 3'd3,
        W_ACC   = 3'd4
    } w_op_t;

    typedef struct packed {
        logic             mul_en;
        mul_a_t           mul_a;
        mul_b_t           mul_b;
        tr_op_t           elig_op;
        tr_op_t           act_op;
        w_op_t            w_op;
        logic             sig_en;
        logic             last;
        logic [PC_W-1:0]  next_pc;
    } ctrl_t;

    localparam logic [PC_W-1:0] UA_STIM  = 4'd0;
    localparam logic [PC_W-1:0] UA_TICK  = 4'd2;
    localparam logic [PC_W-1:0] UA_REW   = 4'd5;
    localparam logic [PC_W-1:0] UA_DOP   = 4'd7;
    localparam logic [PC_W-1:0] UA_SCALE = 4'd10;
    localparam logic [PC_W-1:0] UA_WRS   = 4'd12;
    localparam logic [PC_W-1:0] UA_CLR   = 4'd13;
    localparam logic [PC_W-1:0] UA_NOP   = 4'd14;

    function automatic ctrl_t uword(input logic mul_en, input mul_a_t ma, input mul_b_t mb,
                                    input tr_op_t eop, input tr_op_t aop, input w_op_t wop,
                                    input logic sig, input logic last,
                                    input logic [PC_W-1:0] nxt);
        ctrl_t c;
        c.mul_en  = mul_en;
        c.mul_a   = ma;
        c.mul_b   = mb;
        c.elig_op = eop;
        c.act_op  = aop;
        c.w_op    = wop;
        c.sig_en  = sig;
        c.last    = last;
        c.next_pc = nxt;
        return c;
    endfunction

    // dispatch: first microinstruction for each kind
    function automatic logic [PC_W-1:0] entry(input logic [2:0] kind);
        logic [PC_W-1:0] a;
        unique case (kind)
            KIND_STIMULATE:  a = UA_STIM;
            KIND_TICK:       a = UA_TICK;
            KIND_REWARD:     a = UA_REW;
            KIND_DOPAMINE:   a = UA_DOP;
            KIND_SCALE_ELIG: a = UA_SCALE;
            KIND_WRITE_STR:  a = UA_WRS;
            KIND_CLEAR:      a = UA_CLR;
            default:         a = UA_NOP;
        endcase
        return a;
    endfunction

    // control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        unique case (pc)
            4'd0:  c = uword(1'b1, MA_WEIGHT, MB_AP, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd1);
            4'd1:  c = uword(1'b0, MA_WEIGHT, MB_AP, TR_ONE, TR_ONE, W_KEEP,
                             1'b1, 1'b1, 4'd0);
            4'd2:  c = uword(1'b1, MA_ELIG, MB_EDECAY, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd3);
            4'd3:  c = uword(1'b1, MA_ACT, MB_ADECAY, TR_PROD, TR_KEEP, W_LEAK,
                             1'b0, 1'b0, 4'd4);
            4'd4:  c = uword(1'b0, MA_WEIGHT, MB_AP, TR_KEEP, TR_PROD, W_BOOST,
                             1'b0, 1'b1, 4'd0);
            4'd5:  c = uword(1'b1, MA_AMOUNT, MB_ELIG, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd6);
            4'd6:  c = uword(1'b0, MA_WEIGHT, MB_AP, TR_KEEP, TR_KEEP, W_ACC,
                             1'b0, 1'b1, 4'd0);
            4'd7:  c = uword(1'b1, MA_AMOUNT, MB_ACT, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd8);
            4'd8:  c = uword(1'b1, MA_PROD, MB_GAIN, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd9);
            4'd9:  c = uword(1'b0, MA_WEIGHT, MB_AP, TR_KEEP, TR_KEEP, W_ACC,
                             1'b0, 1'b1, 4'd0);
            4'd10: c = uword(1'b1, MA_ELIG, MB_FACTOR, TR_KEEP, TR_KEEP, W_KEEP,
                             1'b0, 1'b0, 4'd11);
            4'd11: c = uword(1'b0, MA_WEIGHT, MB_AP, TR_PROD, TR_KEEP, W_KEEP,
                             1'b0, 1'b1, 4'd0);
            4'd12: c = uword(1'b0, MA_WEIGHT, MB_AP, TR_KEEP, TR_KEEP, W_LOAD,
                             1'b0, 1'b1, 4'd0);
            4'd13: c = uword(1'b0, MA_WEIGHT, MB_AP, TR_ZERO, TR_ZERO, W_KEEP,
                             1'b0, 1'b1, 4'd0);
            default: c = uword(1'b0, MA_WEIGHT, MB_AP, TR_KEEP, TR_KEEP, W_KEEP,
                               1'b0, 1'b1, 4'd0);
        endcase
        return c;
    endfunction

    function automatic logic signed [23:0] clamp_strength(input logic signed [34:0] x,
                                                          input logic [22:0] m);
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        logic signed [34:0] r;
        hi = $signed({12'b0, m});
        lo = -hi;
        r  = x;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end
        return r[23:0];
    endfunction

endpackage

@@ src/reward_modulated_synapse_update_unit.sv @@
// ----------------------------------------------------------------------------
// reward_modulated_synapse_update_unit
// One plastic synapse in fixed point, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each accepted item runs a short microprogram on one shared 25x25 multiplier
// with a registered product. Tick and dopamine have the longest programs;
// write strength, clear traces and the unused kind have the shortest.
// The multiplier register sets the program lengths: every product needs one
// step to form and one to be written back. The next item is taken in the
// cycle its predecessor's last step completes. Results wait in an output
// register; the last step of an item holds while that register is still full
// and not being taken.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module reward_modulated_synapse_update_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rmsu_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rmsu_pkg::out_t             m_data,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [rmsu_pkg::CFG_W-1:0] cfg_wdata
);

    rmsu_pkg::cfg_t   cfg_reg;
    rmsu_pkg::in_t    item_reg;
    rmsu_pkg::out_t   out_reg;
    rmsu_pkg::out_t   result;
    rmsu_pkg::ctrl_t  ctrl;

    logic                      busy_reg, busy_next;
    logic [rmsu_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      out_free, fire, last_fire, s_xfer;

    assign ctrl      = rmsu_pkg::ucode(pc_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = busy_reg && (!ctrl.last || out_free);
    assign last_fire = fire && ctrl.last;
    assign s_ready   = !busy_reg || last_fire;
    assign s_xfer    = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (s_xfer) begin
            busy_next = 1'b1;
            pc_next   = rmsu_pkg::entry(s_data.kind);
        end else if (last_fire) begin
            busy_next = 1'b0;
        end else if (fire) begin
            pc_next = ctrl.next_pc;
        end
        m_valid_next = m_valid_reg;
        if (last_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= s_data;
        end
        if (last_fire) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.elig_decay       <= 17'd62259;
            cfg_reg.activation_decay <= 17'd58982;
            cfg_reg.rest_level       <= 24'sd32768;
            cfg_reg.leak_step        <= 16'd66;
            cfg_reg.hebb_step        <= 16'd3277;
            cfg_reg.pre_step         <= 16'd655;
            cfg_reg.strength_cap     <= 23'd131072;
            cfg_reg.da_gain          <= 20'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rmsu_pkg::REG_ELIG_DECAY: cfg_reg.elig_decay       <= cfg_wdata[16:0];
                rmsu_pkg::REG_ACT_DECAY:  cfg_reg.activation_decay <= cfg_wdata[16:0];
                rmsu_pkg::REG_REST:       cfg_reg.rest_level       <= cfg_wdata[23:0];
                rmsu_pkg::REG_LEAK:       cfg_reg.leak_step        <= cfg_wdata[15:0];
                rmsu_pkg::REG_HEBB:       cfg_reg.hebb_step        <= cfg_wdata[15:0];
                rmsu_pkg::REG_PING:       cfg_reg.pre_step         <= cfg_wdata[15:0];
                rmsu_pkg::REG_MAX:        cfg_reg.strength_cap     <= cfg_wdata[22:0];
                rmsu_pkg::REG_GAIN:       cfg_reg.da_gain          <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    rmsu_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ctrl    (ctrl),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

@@ src/rmsu_datapath.sv @@
// ----------------------------------------------------------------------------
// rmsu_datapath
// Synapse state, shared multiplier with product register, and the
// write-back units driven by one control word per step.
// ----------------------------------------------------------------------------
module rmsu_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  rmsu_pkg::ctrl_t ctrl,
    input  rmsu_pkg::in_t   item,
    input  rmsu_pkg::cfg_t  cfg,
    output rmsu_pkg::out_t  result
);

    logic signed [23:0] weight_reg, weight_next;
    logic [16:0]        elig_reg, elig_next;
    logic [16:0]        act_reg, act_next;
    logic signed [49:0] prod_reg, prod_next;

    logic signed [24:0] mul_a, mul_b;
    logic signed [33:0] prod_sh;
    logic [16:0]        prod_trace;
    logic signed [23:0] sig_sat;

    logic signed [24:0] w_ext, rest_ext, diff, leak_w;
    logic signed [34:0] acc_sum, boost_sum;
    logic               leak_on;

    assign prod_sh = prod_reg[49:16];

    always_comb begin
        unique case (ctrl.mul_a)
            rmsu_pkg::MA_WEIGHT: mul_a = {weight_reg[23], weight_reg};
            rmsu_pkg::MA_ELIG:   mul_a = {8'b0, elig_reg};
            rmsu_pkg::MA_ACT:    mul_a = {8'b0, act_reg};
            rmsu_pkg::MA_AMOUNT: mul_a = {item.amount[23], item.amount};
            rmsu_pkg::MA_PROD:   mul_a = {prod_sh[23], prod_sh[23:0]};
            default:             mul_a = '0;
        endcase
        unique case (ctrl.mul_b)
            rmsu_pkg::MB_AP:     mul_b = {2'b0, rmsu_pkg::ACTION_POTENTIAL};
            rmsu_pkg::MB_EDECAY: mul_b = {8'b0, cfg.elig_decay};
            rmsu_pkg::MB_ADECAY: mul_b = {8'b0, cfg.activation_decay};
            rmsu_pkg::MB_ELIG:   mul_b = {8'b0, elig_reg};
            rmsu_pkg::MB_ACT:    mul_b = {8'b0, act_reg};
            rmsu_pkg::MB_GAIN:   mul_b = {5'b0, cfg.da_gain};
            rmsu_pkg::MB_FACTOR: mul_b = {8'b0, item.factor};
            default:             mul_b = '0;
        endcase
    end

    assign prod_next = ctrl.mul_en ? mul_a * mul_b : prod_reg;

    // trace products are non-negative; saturate at 1.0
    assign prod_trace = (prod_sh > $signed({17'b0, rmsu_pkg::ONE_Q16})) ?
                        rmsu_pkg::ONE_Q16 : prod_sh[16:0];

    always_comb begin
        if (prod_sh > rmsu_pkg::S24_MAX) begin
            sig_sat = 24'sh7FFFFF;
        end else if (prod_sh < rmsu_pkg::S24_MIN) begin
            sig_sat = 24'sh800000;
        end else begin
            sig_sat = prod_sh[23:0];
        end
    end

    // leak toward rest without overshoot, outside the dead band
    assign w_ext    = {weight_reg[23], weight_reg};
    assign rest_ext = {cfg.rest_level[23], cfg.rest_level};
    assign diff     = w_ext - rest_ext;
    assign leak_on  = (diff > rmsu_pkg::DEAD_BAND) || (diff < -rmsu_pkg::DEAD_BAND);

    always_comb begin
        leak_w = w_ext;
        if (leak_on) begin
            if (w_ext > rest_ext) begin
                leak_w = w_ext - $signed({9'b0, cfg.leak_step});
                if (leak_w < rest_ext) begin
                    leak_w = rest_ext;
                end
            end else begin
                leak_w = w_ext + $signed({9'b0, cfg.leak_step});
                if (leak_w > rest_ext) begin
                    leak_w = rest_ext;
                end
            end
        end
    end

    assign acc_sum = {{11{weight_reg[23]}}, weight_reg} + {prod_sh[33], prod_sh};

    always_comb begin
        boost_sum = {{11{weight_reg[23]}}, weight_reg};
        if (item.post_fired && (elig_reg > rmsu_pkg::ELIG_THRESHOLD)) begin
            boost_sum = boost_sum + $signed({19'b0, cfg.hebb_step});
        end
        if (item.pre_fired) begin
            boost_sum = boost_sum + $signed({19'b0, cfg.pre_step});
        end
    end

    always_comb begin
        unique case (ctrl.w_op)
            rmsu_pkg::W_KEEP:  weight_next = weight_reg;
            rmsu_pkg::W_LOAD:  weight_next = item.amount;
            rmsu_pkg::W_LEAK:  weight_next = leak_w[23:0];
            rmsu_pkg::W_BOOST: weight_next = rmsu_pkg::clamp_strength(boost_sum,
                                                                      cfg.strength_cap);
            rmsu_pkg::W_ACC:   weight_next = rmsu_pkg::clamp_strength(acc_sum,
                                                                      cfg.strength_cap);
            default:           weight_next = weight_reg;
        endcase
        unique case (ctrl.elig_op)
            rmsu_pkg::TR_KEEP: elig_next = elig_reg;
            rmsu_pkg::TR_ONE:  elig_next = rmsu_pkg::ONE_Q16;
            rmsu_pkg::TR_ZERO: elig_next = '0;
            rmsu_pkg::TR_PROD: elig_next = prod_trace;
            default:           elig_next = elig_reg;
        endcase
        unique case (ctrl.act_op)
            rmsu_pkg::TR_KEEP: act_next = act_reg;
            rmsu_pkg::TR_ONE:  act_next = rmsu_pkg::ONE_Q16;
            rmsu_pkg::TR_ZERO: act_next = '0;
            rmsu_pkg::TR_PROD: act_next = prod_trace;
            default:           act_next = act_reg;
        endcase
    end

    always_comb begin
        result.signal          = ctrl.sig_en ? sig_sat : '0;
        result.signal_valid    = ctrl.sig_en;
        result.strength_out    = weight_next;
        result.eligibility_out = elig_next;
        result.activation_out  = act_next;
        result.path_active     = act_next > rmsu_pkg::PATH_THRESHOLD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
            elig_reg   <= '0;
            act_reg    <= '0;
        end else if (fire) begin
            weight_reg <= weight_next;
            elig_reg   <= elig_next;
            act_reg    <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            prod_reg <= prod_next;
        end
    end

endmodule
